// File: rtl/vfcmc_pkg.sv
// Shared types and constants for the vertex fetch cache miss counter.
// No dependencies; the top level, range unit and walker import this package.
`default_nettype none

package vfcmc_pkg;

  // Cache geometry
  localparam int unsigned LINE_BYTES       = 64;
  localparam int unsigned CACHE_BYTES      = 128 * 1024;
  localparam int unsigned MAX_VERTEX_BYTES = 256;

  localparam int unsigned NUM_LINES = CACHE_BYTES / LINE_BYTES;
  localparam int unsigned OFFS_W    = $clog2(LINE_BYTES);
  localparam int unsigned SLOT_W    = $clog2(NUM_LINES);

  // Field widths
  localparam int unsigned IDX_W   = 32;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned TOTAL_W = 48;

  // Derived address widths
  localparam int unsigned ADDR_W = IDX_W + SIZE_W;
  localparam int unsigned LINE_W = ADDR_W - OFFS_W;
  localparam int unsigned TAG_W  = LINE_W - SLOT_W;
  localparam int unsigned SPAN_W = $clog2(LINE_BYTES + MAX_VERTEX_BYTES);

  localparam logic [SIZE_W-1:0]  VSIZE_RST = SIZE_W'(16);
  localparam logic [SIZE_W-1:0]  VSIZE_MIN = SIZE_W'(1);
  localparam logic [SIZE_W-1:0]  VSIZE_MAX = SIZE_W'(MAX_VERTEX_BYTES);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [TOTAL_W-1:0] LINE_INC  = TOTAL_W'(LINE_BYTES);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last_index;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]   lines_touched;
    logic [CNT_W-1:0]   lines_missed;
    logic [TOTAL_W-1:0] total_bytes;
    logic               done_res;
  } res_t;

  // One tag store entry
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } tag_entry_t;

  localparam int unsigned ENTRY_W = $bits(tag_entry_t);

  // Line range of the vertex in flight, handed to the walker
  typedef struct packed {
    logic [LINE_W-1:0] first_line;
    logic [CNT_W-1:0]  touched;
    logic              last;
  } range_t;

endpackage

`default_nettype wire

// File: rtl/vertex_fetch_cache_miss_counter_top.sv
// Top level of the vertex fetch cache miss counter: vertex size register,
// range unit and line walker. Depends on vfcmc_pkg, vfcmc_range, vfcmc_walk.
//
// After reset the block clears its 2048-entry tag store with busy_o high;
// the vertex size register can be written during that time.
// Each accepted index then keeps busy_o high through one step for the index
// by size multiply, one to issue the first tag read, and one tag
// read-modify-write per line on the single tag memory, for each of the N
// (1 to 5) 64-byte lines the vertex covers. A new index can be taken as soon
// as busy_o is low; none is taken while busy_o is high.
// Each result beat is shown on res_o for exactly one cycle with res_valid_o
// high, in the cycle busy_o falls; the receiver cannot stall it.
`default_nettype none

module vertex_fetch_cache_miss_counter_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [vfcmc_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  wire logic                          start_i,
  input  wire vfcmc_pkg::in_t                in_i,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output vfcmc_pkg::res_t                    res_o
);

  import vfcmc_pkg::*;

  logic [SIZE_W-1:0] vsize_q;
  logic              accept;
  range_t            range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsize_q <= VSIZE_RST;
    end else if (cfg_we_i) begin
      vsize_q <= cfg_wdata_i;
    end
  end

  assign accept = start_i && !busy_o;

  vfcmc_range u_range (
    .clk_i   (clk_i),
    .load_i  (accept),
    .in_i    (in_i),
    .vsize_i (vsize_q),
    .range_o (range)
  );

  vfcmc_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (accept),
    .range_i     (range),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: rtl/vfcmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vfcmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/vfcmc_range.sv
// Byte range unit: clamps the vertex size, multiplies it by the index and
// derives the first cache line and the line count. Depends on vfcmc_pkg.
`default_nettype none

module vfcmc_range (
  input  wire logic                          clk_i,
  input  wire logic                          load_i,
  input  wire vfcmc_pkg::in_t                in_i,
  input  wire logic [vfcmc_pkg::SIZE_W-1:0]  vsize_i,
  output vfcmc_pkg::range_t                  range_o
);

  import vfcmc_pkg::*;

  logic [IDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] size_eff;
  logic              last_q;
  logic [ADDR_W-1:0] prod_q;
  logic [SPAN_W-1:0] span;

  always_comb begin
    size_eff = vsize_i;
    if (vsize_i == '0) begin
      size_eff = VSIZE_MIN;
    end else if (vsize_i > VSIZE_MAX) begin
      size_eff = VSIZE_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      idx_q  <= in_i.index;
      size_q <= size_eff;
      last_q <= in_i.last_index;
    end
    prod_q <= ADDR_W'(idx_q) * ADDR_W'(size_q);
  end

  // Offset of the last byte relative to the first line's base
  assign span = SPAN_W'(prod_q[OFFS_W-1:0]) + SPAN_W'(size_q) - SPAN_W'(1);

  assign range_o.first_line = prod_q[ADDR_W-1:OFFS_W];
  assign range_o.touched    = CNT_W'(span >> OFFS_W) + CNT_W'(1);
  assign range_o.last       = last_q;

endmodule

`default_nettype wire

// File: rtl/vfcmc_walk.sv
// Line walker: clears the tag store after reset, then does one tag
// read-modify-write per covered line and keeps the byte total.
// Depends on vfcmc_pkg and vfcmc_ram.
`default_nettype none

module vfcmc_walk (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              go_i,
  input  wire vfcmc_pkg::range_t range_i,
  output logic                   busy_o,
  output logic                   res_valid_o,
  output vfcmc_pkg::res_t        res_o
);

  import vfcmc_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_RD    = 5'b01000,
    ST_CMP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [SLOT_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [LINE_W-1:0]  line_q, line_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   missed_q, missed_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  tag_entry_t         ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  logic [LINE_W-1:0]  line_next;
  logic               hit;
  logic               last_line;

  vfcmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = tag_entry_t'(ram_rdata_raw);
  assign line_next = line_q + LINE_W'(1);
  assign hit       = ram_rdata.valid && (ram_rdata.tag == line_q[LINE_W-1:SLOT_W]);
  assign last_line = (cnt_q == range_i.touched - CNT_W'(1));

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    line_d      = line_q;
    cnt_d       = cnt_q;
    missed_d    = missed_q;
    total_d     = total_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = line_q[SLOT_W-1:0];
    ram_wdata   = '{valid: 1'b1, tag: line_q[LINE_W-1:SLOT_W]};
    ram_re      = 1'b0;
    ram_raddr   = range_i.first_line[SLOT_W-1:0];

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + SLOT_W'(1);
        if (clr_cnt_q == SLOT_W'(NUM_LINES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_RD;
      end
      ST_RD: begin
        ram_re   = 1'b1;
        line_d   = range_i.first_line;
        cnt_d    = '0;
        missed_d = '0;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (!hit) begin
          missed_d = missed_q + CNT_W'(1);
          if (total_q > TOTAL_MAX - LINE_INC) begin
            total_d = TOTAL_MAX;
          end else begin
            total_d = total_q + LINE_INC;
          end
        end
        cnt_d  = cnt_q + CNT_W'(1);
        line_d = line_next;
        if (last_line) begin
          res_valid_d         = 1'b1;
          res_d.lines_touched = range_i.touched;
          res_d.lines_missed  = missed_d;
          res_d.total_bytes   = total_d;
          res_d.done_res      = range_i.last;
          state_d             = ST_IDLE;
        end else begin
          // Prefetch the next line; it is always a different slot
          ram_re    = 1'b1;
          ram_raddr = line_next[SLOT_W-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      missed_q    <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      cnt_q       <= cnt_d;
      missed_q    <= missed_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("tag store read and write hit the same slot");

  a_strobe_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (cnt_q < range_i.touched))
    else $error("line counter ran past the covered lines");

  a_missed_le_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.lines_missed <= res_q.lines_touched))
    else $error("more misses than lines");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (total_q >= $past(total_q)))
    else $error("byte total decreased");

endmodule

`default_nettype wire

// File: test/tb_vertex_fetch_cache_miss_counter_top.sv
// Testbench for the vertex fetch cache miss counter: directed table, then random index streams.
// Expects typed rows, else its own tag store model; depends on vfcmc_pkg and the top level.
`timescale 1ns / 100ps

module tb_vertex_fetch_cache_miss_counter_top;
  import vfcmc_pkg::*;

  localparam int unsigned STALL_LIMIT  = 6000;
  localparam int unsigned RAND_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned SCRIPT_ROWS  = 20;
  localparam logic [TOTAL_W-1:0] BYTES_CEIL = '1;

  typedef struct packed {
    bit               set_size;
    bit [SIZE_W-1:0]  size;
    bit [IDX_W-1:0]   index;
    bit               last;
    bit               typed;
    bit [CNT_W-1:0]   touched;
    bit [CNT_W-1:0]   missed;
    bit [TOTAL_W-1:0] total;
  } script_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;
  logic              start_i;
  in_t               in_i;
  logic              busy_o;
  logic              res_valid_o;
  res_t              res_o;

  // predictor state, cleared like the block after reset
  logic [SIZE_W-1:0]  vsize_q = VSIZE_RST;
  bit                 line_valid [NUM_LINES];
  longint unsigned    line_tag   [NUM_LINES];
  logic [TOTAL_W-1:0] fetched_bytes = '0;
  res_t               fetch_q [$];

  // typed expectation for the beat being offered
  bit                 use_typed;
  res_t               typed_res;

  int unsigned        errors = 0;
  int unsigned        stall_cycles = 0;
  script_row_t        script [SCRIPT_ROWS];

  vertex_fetch_cache_miss_counter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Walk every line of the vertex range through the direct-mapped tag store.
  function automatic res_t fetch_vertex(in_t item);
    longint unsigned sz, first_byte, first_line, stop_line, ln, tag;
    int unsigned     slot;
    res_t            r;
    sz = longint'(vsize_q);
    if (sz == 0) sz = 1;
    if (sz > MAX_VERTEX_BYTES) sz = MAX_VERTEX_BYTES;
    first_byte = longint'(item.index) * sz;
    first_line = first_byte / LINE_BYTES;
    stop_line  = (first_byte + sz + LINE_BYTES - 1) / LINE_BYTES;
    r = '0;
    for (ln = first_line; ln < stop_line; ln++) begin
      slot = int'(ln % NUM_LINES);
      tag  = ln / NUM_LINES;
      r.lines_touched++;
      if (!line_valid[slot] || line_tag[slot] != tag) begin
        r.lines_missed++;
        if (fetched_bytes > BYTES_CEIL - LINE_BYTES) fetched_bytes = BYTES_CEIL;
        else fetched_bytes = fetched_bytes + LINE_BYTES;
      end
      line_valid[slot] = 1'b1;
      line_tag[slot]   = tag;
    end
    r.total_bytes = fetched_bytes;
    r.done_res    = item.last_index;
    return r;
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin : monitor
    res_t want, pred;
    bit   took;
    if (rst_ni) begin
      took = start_i && !busy_o;
      if (res_valid_o) begin
        if (fetch_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, res_o);
          errors++;
        end else begin
          want = fetch_q.pop_front();
          if (res_o.lines_touched !== want.lines_touched)
            report_field("lines_touched", want.lines_touched, res_o.lines_touched);
          if (res_o.lines_missed !== want.lines_missed)
            report_field("lines_missed", want.lines_missed, res_o.lines_missed);
          if (res_o.total_bytes !== want.total_bytes)
            report_field("total_bytes", want.total_bytes, res_o.total_bytes);
          if (res_o.done_res !== want.done_res)
            report_field("done_res", want.done_res, res_o.done_res);
        end
      end
      if (took) begin
        pred = fetch_vertex(in_i);
        fetch_q.push_back(use_typed ? typed_res : pred);
      end
      if (cfg_we_i) vsize_q = cfg_wdata_i;
      if (took || res_valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one index beat after an idle gap; return at the accepting edge.
  task automatic send_vertex(in_t item, int unsigned gap, bit typed, res_t want);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    use_typed = typed;
    typed_res = want;
    start_i <= 1'b1;
    in_i    <= item;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and hold until every expected result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (fetch_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_vertex_size(logic [SIZE_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    in_t             item;
    res_t            want;
    logic [IDX_W-1:0] base, prev;
    logic [SIZE_W-1:0] sz;
    int unsigned     pause_at, gap;
    bit              burst;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    start_i      = 1'b0;
    in_i         = '0;
    use_typed    = 1'b0;
    typed_res    = '0;

    // set_size, size, index, last, typed, touched, missed, total
    script = '{
      '{1'b0, 9'd16,  32'h0000_0000, 1'b0, 1'b1, 3'd1, 3'd1, 48'd64},
      '{1'b0, 9'd16,  32'h0000_0000, 1'b0, 1'b1, 3'd1, 3'd0, 48'd64},
      '{1'b0, 9'd16,  32'h0000_0003, 1'b0, 1'b1, 3'd1, 3'd0, 48'd64},
      '{1'b0, 9'd16,  32'h0000_0004, 1'b0, 1'b1, 3'd1, 3'd1, 48'd128},
      '{1'b0, 9'd16,  32'hFFFF_FFFF, 1'b1, 1'b1, 3'd1, 3'd1, 48'd192},
      '{1'b1, 9'd256, 32'h0000_0000, 1'b0, 1'b1, 3'd4, 3'd2, 48'd320},
      '{1'b0, 9'd256, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd4, 3'd4, 48'd576},
      '{1'b1, 9'd0,   32'h0000_0000, 1'b0, 1'b1, 3'd1, 3'd0, 48'd576},
      '{1'b0, 9'd0,   32'h0000_0040, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd511, 32'h0000_0001, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd250, 32'h0000_0001, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd257, 32'h0000_0002, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd1,   32'h0000_0000, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b0, 9'd1,   32'h8000_0000, 1'b1, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd64,  32'h0000_0000, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b0, 9'd64,  32'h0000_0800, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b0, 9'd64,  32'h0000_0000, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b0, 9'd64,  32'h7FFF_FFFF, 1'b1, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd255, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0, 3'd0, 48'd0},
      '{1'b1, 9'd16,  32'h5555_AAAA, 1'b1, 1'b0, 3'd0, 3'd0, 48'd0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[r]) begin
      if (script[r].set_size) write_vertex_size(script[r].size);
      item.index      = script[r].index;
      item.last_index = script[r].last;
      want.lines_touched = script[r].touched;
      want.lines_missed  = script[r].missed;
      want.total_bytes   = script[r].total;
      want.done_res      = script[r].last;
      send_vertex(item, $urandom_range(0, 3), script[r].typed, want);
    end

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: sz = VSIZE_MIN;
        1: sz = VSIZE_MAX;
        2: sz = '0;
        3: sz = '1;
        4: sz = 9'd255;
        default: sz = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 511))
                                                  : SIZE_W'($urandom_range(1, 64));
      endcase
      write_vertex_size(sz);
      base     = $urandom;
      prev     = base;
      burst    = (ph % 3 == 0);
      pause_at = $urandom_range(1, PHASE_ITEMS - 1);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // mostly local indices so lines get reused, with aliases and noise mixed in
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: item.index = base + $urandom_range(0, 63);
          5, 6:          item.index = prev + 1;
          7:             item.index = prev + $urandom_range(1, 15) * 131072;
          8:             item.index = $urandom;
          default:       item.index = base + $urandom_range(0, 1023);
        endcase
        item.last_index = ($urandom_range(0, 15) == 0);
        prev = item.index;
        if (n == pause_at) drain_results();
        gap = (burst && n < PHASE_ITEMS / 2) ? 0 : $urandom_range(0, 16);
        send_vertex(item, gap, 1'b0, '0);
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
